### rtl/core/irpd_pkg.sv
// Package for the IR remote pulse decoder: item codes, register indexes,
// frame constants and register reset values. No dependencies.
package irpd_pkg;

   localparam int unsigned EDGE_IDX_W = 6;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned WIN_W      = 15;
   localparam int unsigned KEY_W      = 8;

   // Edge count that completes a frame
   localparam logic [EDGE_IDX_W-1:0] EDGES_PER_FRAME = 6'd34;

   // Command byte (frame bits 23:16) of the two keys, bit 16 in the LSB
   localparam logic [7:0] KEY_PATTERN_ZERO = 8'h16;
   localparam logic [7:0] KEY_PATTERN_ONE  = 8'h0C;

   localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
   localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
   localparam logic [KEY_W-1:0] KEY_ONE  = 8'h31;

   localparam logic [15:0]      LEAD_MIN_RST   = 16'd13000;
   localparam logic [15:0]      LEAD_MAX_RST   = 16'd14000;
   localparam logic [15:0]      REPEAT_MIN_RST = 16'd11000;
   localparam logic [15:0]      REPEAT_MAX_RST = 16'd12000;
   localparam logic [WIN_W-1:0] ZERO_MIN_RST   = 15'd1000;
   localparam logic [WIN_W-1:0] ZERO_MAX_RST   = 15'd1500;
   localparam logic [WIN_W-1:0] ONE_MIN_RST    = 15'd2000;
   localparam logic [WIN_W-1:0] ONE_MAX_RST    = 15'd2500;

   typedef enum logic {
      CMD_EDGE  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEAD_MIN   = 3'd0,
      CSR_LEAD_MAX   = 3'd1,
      CSR_REPEAT_MIN = 3'd2,
      CSR_REPEAT_MAX = 3'd3,
      CSR_ZERO_MIN   = 3'd4,
      CSR_ZERO_MAX   = 3'd5,
      CSR_ONE_MIN    = 3'd6,
      CSR_ONE_MAX    = 3'd7
   } csr_idx_type;

endpackage

### rtl/core/ir_remote_pulse_decoder_top.sv
// IR remote pulse decoder: edge timing, bit classification, key match.
// Depends on irpd_pkg.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_command, req_timestamp_us
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_key_code, rsp_done_flag
//  csr     | in        | csr_we (no wait)     | csr_index, csr_wdata
//
// The item is held in an input register, then one pass of subtract, window
// compares and key match updates the decoder state, which is the result
// register. One item per cycle is taken while rsp is drained.
// A stalled result blocks the input register, and req_ready then falls.
// Reset clears both valid bits, the edge count, frame bits, key and done flag
// and restores the window registers; the last edge time needs no reset.
module ir_remote_pulse_decoder_top #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [31:0]                       req_timestamp_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [irpd_pkg::KEY_W-1:0]        rsp_key_code,
   output logic                              rsp_done_flag,
   input  logic                              csr_we,
   input  logic [irpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [irpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import irpd_pkg::*;

   // Window registers
   logic [15:0]      lead_min_ff, lead_max_ff, rep_min_ff, rep_max_ff;
   logic [WIN_W-1:0] zero_min_ff, zero_max_ff, one_min_ff, one_max_ff;

   // Input stage
   logic                  s1_valid_ff;
   cmd_type               s1_cmd_ff;
   logic [TIME_WIDTH-1:0] s1_time_ff;
   logic                  s1_adv;

   // Decoder state, also the result register
   logic                  out_valid_ff;
   logic [EDGE_IDX_W-1:0] edge_idx_ff, edge_idx_in;
   logic [TIME_WIDTH-1:0] last_time_ff;
   logic [31:0]           frame_ff, frame_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic                  done_ff, done_in;

   logic [TIME_WIDTH-1:0] interval;
   logic [15:0]           ival16;
   logic                  is_lead, is_repeat, is_zero, is_one;
   logic [EDGE_IDX_W-1:0] bit_pos_full, idx_mid, idx_inc;
   logic [4:0]            bit_pos;
   logic [7:0]            cmd_byte;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_code  = key_ff;
   assign rsp_done_flag = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_min_ff <= LEAD_MIN_RST;
         lead_max_ff <= LEAD_MAX_RST;
         rep_min_ff  <= REPEAT_MIN_RST;
         rep_max_ff  <= REPEAT_MAX_RST;
         zero_min_ff <= ZERO_MIN_RST;
         zero_max_ff <= ZERO_MAX_RST;
         one_min_ff  <= ONE_MIN_RST;
         one_max_ff  <= ONE_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LEAD_MIN:   lead_min_ff <= csr_wdata;
            CSR_LEAD_MAX:   lead_max_ff <= csr_wdata;
            CSR_REPEAT_MIN: rep_min_ff  <= csr_wdata;
            CSR_REPEAT_MAX: rep_max_ff  <= csr_wdata;
            CSR_ZERO_MIN:   zero_min_ff <= csr_wdata[WIN_W-1:0];
            CSR_ZERO_MAX:   zero_max_ff <= csr_wdata[WIN_W-1:0];
            CSR_ONE_MIN:    one_min_ff  <= csr_wdata[WIN_W-1:0];
            CSR_ONE_MAX:    one_max_ff  <= csr_wdata[WIN_W-1:0];
            default:        lead_min_ff <= lead_min_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff  <= cmd_type'(req_command);
         s1_time_ff <= req_timestamp_us[TIME_WIDTH-1:0];
      end
   end

   // Interval and window classification
   always_comb begin
      interval  = s1_time_ff - last_time_ff;
      ival16    = interval[15:0];
      is_lead   = (interval > TIME_WIDTH'(lead_min_ff)) &&
                  (interval < TIME_WIDTH'(lead_max_ff));
      is_repeat = (interval > TIME_WIDTH'(rep_min_ff)) &&
                  (interval < TIME_WIDTH'(rep_max_ff));
      // negative after the 16-bit cut never falls in a bit window
      is_zero   = !ival16[15] && (ival16[WIN_W-1:0] > zero_min_ff) &&
                  (ival16[WIN_W-1:0] < zero_max_ff);
      is_one    = !ival16[15] && (ival16[WIN_W-1:0] > one_min_ff) &&
                  (ival16[WIN_W-1:0] < one_max_ff);
      bit_pos_full = edge_idx_ff - EDGE_IDX_W'(2);
      bit_pos      = bit_pos_full[4:0];
   end

   // Next decoder state for the item in the input stage
   always_comb begin
      edge_idx_in = edge_idx_ff;
      frame_in    = frame_ff;
      key_in      = key_ff;
      done_in     = done_ff;
      idx_mid     = edge_idx_ff;
      cmd_byte    = 8'h00;
      idx_inc     = edge_idx_ff;
      if (s1_cmd_ff == CMD_CLEAR) begin
         done_in = 1'b0;
      end else begin
         if (edge_idx_ff != '0) begin
            if (is_lead) begin
               idx_mid = EDGE_IDX_W'(1);
            end else begin
               if (is_repeat) begin
                  done_in = 1'b1;
               end
               if (edge_idx_ff >= EDGE_IDX_W'(2)) begin
                  priority if (is_zero) begin
                     frame_in[bit_pos] = 1'b0;
                  end else if (is_one) begin
                     frame_in[bit_pos] = 1'b1;
                  end else begin
                     // out of both windows: the bit keeps its old value
                  end
               end
            end
         end
         idx_inc  = idx_mid + EDGE_IDX_W'(1);
         cmd_byte = frame_in[23:16];
         if (idx_inc == EDGES_PER_FRAME) begin
            edge_idx_in = '0;
            priority if (cmd_byte == KEY_PATTERN_ZERO) begin
               key_in  = KEY_ZERO;
               done_in = 1'b1;
            end else if (cmd_byte == KEY_PATTERN_ONE) begin
               key_in  = KEY_ONE;
               done_in = 1'b1;
            end else begin
               key_in = KEY_NONE;
            end
         end else begin
            edge_idx_in = idx_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         edge_idx_ff  <= '0;
         frame_ff     <= '0;
         key_ff       <= KEY_NONE;
         done_ff      <= 1'b0;
      end else begin
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
            edge_idx_ff  <= edge_idx_in;
            frame_ff     <= frame_in;
            key_ff       <= key_in;
            done_ff      <= done_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (s1_cmd_ff == CMD_EDGE)) begin
         last_time_ff <= s1_time_ff;
      end
   end

endmodule

### rtl/core/irpd_checker.sv
// Port-level checks for the IR remote pulse decoder, bound to the top level.
// Depends on irpd_pkg and ir_remote_pulse_decoder_top.
module irpd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [irpd_pkg::KEY_W-1:0]       rsp_key_code,
   input logic                             rsp_done_flag
);
   import irpd_pkg::*;

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code) &&
      $stable(rsp_done_flag))
      else $error("rsp payload changed while stalled");

   a_key_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_code == KEY_NONE) || (rsp_key_code == KEY_ZERO) ||
      (rsp_key_code == KEY_ONE))
      else $error("illegal key code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // with the result side empty, the input stage always drains
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty result register");

endmodule

bind ir_remote_pulse_decoder_top irpd_checker u_irpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_key_code  (rsp_key_code),
   .rsp_done_flag (rsp_done_flag)
);

### tb/sv/ir_remote_pulse_decoder_top_tb.sv
// Self-checking testbench for ir_remote_pulse_decoder_top: NEC-style edge frames,
// repeat codes, clear commands and noise against an in-bench decoder tracker.
// Depends on irpd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module ir_remote_pulse_decoder_top_tb;
   import irpd_pkg::*;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] ts;
   } edge_item_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             done;
   } key_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = 1'b0;
   logic [31:0]           req_timestamp_us = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KEY_W-1:0]      rsp_key_code;
   logic                  rsp_done_flag;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ir_remote_pulse_decoder_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_timestamp_us (req_timestamp_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_done_flag    (rsp_done_flag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   edge_item_type  edge_items[$];
   key_report_type key_reports[$];
   edge_item_type  held;
   logic [31:0] stim_time = '0;
   int          fail_count = 0;
   int          send_idle_pct = 15;
   int          recv_idle_pct = 49;
   logic        holdoff_armed = 1'b0;
   logic        holdoff_taken = 1'b0;
   int          holdoff_left = 0;

   // decoder tracker state
   logic [15:0]           trk_win [8];
   logic [EDGE_IDX_W-1:0] trk_idx;
   logic [31:0]           trk_last;
   logic [31:0]           trk_bits;
   logic [KEY_W-1:0]      trk_key;
   logic                  trk_done;

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   task automatic track_decoder(cmd_type cmd, logic [31:0] ts);
      logic [31:0]        span;
      logic signed [15:0] cut;
      int                 d;
      logic [4:0]         pos;
      key_report_type     rpt;
      if (cmd == CMD_CLEAR) begin
         trk_done = 1'b0;
      end else begin
         span = ts - trk_last;
         trk_last = ts;
         if (trk_idx != '0) begin
            if (span > {16'd0, trk_win[CSR_LEAD_MIN]} &&
                span < {16'd0, trk_win[CSR_LEAD_MAX]}) begin
               trk_idx = EDGE_IDX_W'(1);
            end else begin
               if (span > {16'd0, trk_win[CSR_REPEAT_MIN]} &&
                   span < {16'd0, trk_win[CSR_REPEAT_MAX]})
                  trk_done = 1'b1;
               if (trk_idx >= EDGE_IDX_W'(2)) begin
                  // bit windows judge the interval as 16-bit signed
                  cut = span[15:0];
                  d   = int'(cut);
                  pos = 5'(trk_idx - EDGE_IDX_W'(2));
                  if (d > int'(trk_win[CSR_ZERO_MIN]) && d < int'(trk_win[CSR_ZERO_MAX]))
                     trk_bits[pos] = 1'b0;
                  else if (d > int'(trk_win[CSR_ONE_MIN]) && d < int'(trk_win[CSR_ONE_MAX]))
                     trk_bits[pos] = 1'b1;
               end
            end
         end
         trk_idx = trk_idx + EDGE_IDX_W'(1);
         if (trk_idx == EDGES_PER_FRAME) begin
            trk_idx = '0;
            trk_key = KEY_NONE;
            if (trk_bits[23:16] == KEY_PATTERN_ZERO) begin
               trk_key  = KEY_ZERO;
               trk_done = 1'b1;
            end else if (trk_bits[23:16] == KEY_PATTERN_ONE) begin
               trk_key  = KEY_ONE;
               trk_done = 1'b1;
            end
         end
      end
      rpt.key  = trk_key;
      rpt.done = trk_done;
      key_reports.push_back(rpt);
   endtask

   // Driver: holds the current item until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            track_decoder(held.cmd, held.ts);
         if (!req_valid || req_ready) begin
            if (edge_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               held = edge_items.pop_front();
               req_valid        <= 1'b1;
               req_command      <= held.cmd;
               req_timestamp_us <= held.ts;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready, with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_armed && !holdoff_taken) begin
         holdoff_taken <= 1'b1;
         holdoff_left  <= 300;
         rsp_ready     <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Monitor
   always @(posedge clock) begin
      key_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (key_reports.size() == 0) begin
            note_failure($sformatf("unexpected result key=%h done=%b",
                                   rsp_key_code, rsp_done_flag));
         end else begin
            want = key_reports.pop_front();
            if (rsp_key_code !== want.key || rsp_done_flag !== want.done)
               note_failure($sformatf("expected key=%h done=%b, got key=%h done=%b",
                                      want.key, want.done, rsp_key_code, rsp_done_flag));
         end
      end
   end

   task automatic add_item(cmd_type cmd, logic [31:0] ts);
      edge_item_type it;
      it.cmd = cmd;
      it.ts  = ts;
      edge_items.push_back(it);
   endtask

   task automatic add_edge_at(logic [31:0] ts);
      stim_time = ts;
      add_item(CMD_EDGE, ts);
   endtask

   task automatic add_edge(logic [31:0] gap);
      add_edge_at(stim_time + gap);
   endtask

   // strictly inside an exclusive window, or anything when the window is empty
   function automatic logic [31:0] pick_in(logic [15:0] lo, logic [15:0] hi);
      if (hi > lo + 17'd1)
         return $urandom_range(hi - 1, lo + 1);
      return $urandom_range(65535, 0);
   endfunction

   task automatic add_frame();
      logic [31:0] bits;
      logic [31:0] gap;
      bits = $urandom;
      case ($urandom_range(2, 0))
         0: bits[23:16] = KEY_PATTERN_ZERO;
         1: bits[23:16] = KEY_PATTERN_ONE;
         default: ;
      endcase
      add_edge($urandom_range(60000, 20000));
      add_edge(pick_in(trk_win[CSR_LEAD_MIN], trk_win[CSR_LEAD_MAX]));
      for (int i = 0; i < 32; i++) begin
         gap = bits[i] ? pick_in(trk_win[CSR_ONE_MIN], trk_win[CSR_ONE_MAX])
                       : pick_in(trk_win[CSR_ZERO_MIN], trk_win[CSR_ZERO_MAX]);
         if ($urandom_range(39, 0) == 0)
            gap = $urandom_range(65535, 0);
         add_edge(gap);
      end
      if ($urandom_range(3, 0) == 0)
         repeat ($urandom_range(3, 1))
            add_edge(pick_in(trk_win[CSR_REPEAT_MIN], trk_win[CSR_REPEAT_MAX]));
      if ($urandom_range(2, 0) == 0)
         add_item(CMD_CLEAR, $urandom);
   endtask

   task automatic add_noise();
      case ($urandom_range(5, 0))
         0: add_edge_at($urandom);
         1: add_edge($urandom);
         2: add_edge($urandom_range(3000, 0));
         3: add_item(CMD_CLEAR, $urandom);
         4: add_edge(pick_in(trk_win[CSR_REPEAT_MIN], trk_win[CSR_REPEAT_MAX]));
         default: add_edge(pick_in(trk_win[CSR_LEAD_MIN], trk_win[CSR_LEAD_MAX]));
      endcase
   endtask

   task automatic add_random(int n, int frame_pct);
      int goal;
      goal = edge_items.size() + n;
      while (edge_items.size() < goal) begin
         if ($urandom_range(99, 0) < frame_pct)
            add_frame();
         else
            add_noise();
      end
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (edge_items.size() != 0 || req_valid || key_reports.size() != 0);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      trk_win[idx] = (idx >= CSR_ZERO_MIN) ? (data & 16'h7FFF) : data;
   endtask

   task automatic set_windows(logic [15:0] lead_lo, logic [15:0] lead_hi,
                              logic [15:0] rep_lo, logic [15:0] rep_hi,
                              logic [15:0] zero_lo, logic [15:0] zero_hi,
                              logic [15:0] one_lo, logic [15:0] one_hi);
      csr_write(CSR_LEAD_MIN, lead_lo);
      csr_write(CSR_LEAD_MAX, lead_hi);
      csr_write(CSR_REPEAT_MIN, rep_lo);
      csr_write(CSR_REPEAT_MAX, rep_hi);
      csr_write(CSR_ZERO_MIN, zero_lo);
      csr_write(CSR_ZERO_MAX, zero_hi);
      csr_write(CSR_ONE_MIN, one_lo);
      csr_write(CSR_ONE_MAX, one_hi);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      trk_win[CSR_LEAD_MIN]   = LEAD_MIN_RST;
      trk_win[CSR_LEAD_MAX]   = LEAD_MAX_RST;
      trk_win[CSR_REPEAT_MIN] = REPEAT_MIN_RST;
      trk_win[CSR_REPEAT_MAX] = REPEAT_MAX_RST;
      trk_win[CSR_ZERO_MIN]   = {1'b0, ZERO_MIN_RST};
      trk_win[CSR_ZERO_MAX]   = {1'b0, ZERO_MAX_RST};
      trk_win[CSR_ONE_MIN]    = {1'b0, ONE_MIN_RST};
      trk_win[CSR_ONE_MAX]    = {1'b0, ONE_MAX_RST};
      trk_idx  = '0;
      trk_last = '0;
      trk_bits = '0;
      trk_key  = KEY_NONE;
      trk_done = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: wrap, boundaries, cut to 16 bits, repeat, lead, clear
      add_item(CMD_CLEAR, 32'hFFFF_FFFF);
      add_edge_at(32'hFFFF_FFFF);
      add_edge(32'd1);
      add_edge(32'd1200);
      add_edge(32'd2200);
      add_edge(32'h8000 + 32'd1200);
      add_edge(32'h1_0000 + 32'd2200);
      add_edge(32'hFFFF);
      add_edge(32'd11500);
      add_item(CMD_CLEAR, 32'd0);
      add_edge(32'd13500);
      add_edge(32'd13000);
      add_edge(32'd14000);
      add_edge(32'd11000);
      add_edge(32'd12000);
      add_edge(32'd1000);
      add_edge(32'd1500);
      add_edge(32'd2000);
      add_edge(32'd2500);
      add_edge(32'd0);
      add_edge(32'hFFFF_FFFF);
      add_edge(32'h7FFF);
      add_random(200, 75);
      wait_idle();

      send_idle_pct = 49;
      recv_idle_pct = 15;
      // bit 15 on a 15-bit window register is dropped by the block
      set_windows(16'd9000, 16'd10000, 16'd4000, 16'd6000,
                  16'h8000 | 16'd400, 16'd700, 16'd1000, 16'd1400);
      add_random(200, 75);
      wait_idle();

      // extremes: no lead, repeat on almost anything, all positive bits zero
      set_windows(16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
                  16'd0, 16'h7FFF, 16'h7FFF, 16'd0);
      add_random(60, 30);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // extremes: lead on almost anything, no repeat, all positive bits one
      set_windows(16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                  16'hFFFF, 16'd0, 16'd0, 16'h7FFF);
      add_random(60, 30);
      wait_idle();

      set_windows(LEAD_MIN_RST, LEAD_MAX_RST, REPEAT_MIN_RST, REPEAT_MAX_RST,
                  {1'b0, ZERO_MIN_RST}, {1'b0, ZERO_MAX_RST},
                  {1'b0, ONE_MIN_RST}, {1'b0, ONE_MAX_RST});
      @(negedge clock);
      holdoff_armed = 1'b1;
      add_random(130, 80);
      wait_idle();

      repeat (10) @(posedge clock);
      if (fail_count == 0 && key_reports.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ERROR: timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
